// ===== rtl/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Holds the beat formats of both channels, the operation and status codes,
// the controller states and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Default store depth and the fixed field widths of the beats.
	localparam int CAPACITY_DEF  = 16;
	localparam int DATA_BITS     = 32;
	localparam int PRIORITY_BITS = 16;
	localparam int COUNT_BITS    = 5;

	// Operation codes; the unused code is served as a peek.
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// Request beat.
	typedef struct packed {
		logic [1:0]                     opcode;
		logic [DATA_BITS-1:0]           item_data;
		logic signed [PRIORITY_BITS-1:0] item_priority;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [1:0]                     status;
		logic [DATA_BITS-1:0]           head_data;
		logic signed [PRIORITY_BITS-1:0] head_priority;
		logic [COUNT_BITS-1:0]          item_count;
		logic                           is_empty;
	} rsp_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_CMP,
		S_ENQ_DONE,
		S_RD_HEAD,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       latch_in;
		logic       status_load;
		logic [1:0] status_code;
		logic       cap_head;
		logic       cap_zero;
		logic       deq_commit;
		logic       head_load;
		logic       scan_init;
		logic       scan_read;
		logic       write_new;
		logic       write_shift;
		logic       out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       full;
		logic       last_item;
		logic       scan_done;
		logic       rd_ge;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/spq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port and one read port with a registered read data output that
// updates only when a read is enabled.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl: operation sequencer of the stable priority queue
// Accepts one request beat at a time, decodes it and steps the datapath
// through the insertion scan, the head reload and the response hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (sts.op)
					OP_ENQ: begin
						state_d = sts.full ? S_FINISH : S_SCAN;
					end
					OP_DEQ: begin
						if (sts.empty || sts.last_item) state_d = S_FINISH;
						else state_d = S_RD_HEAD;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SCAN: begin
				state_d = sts.scan_done ? S_ENQ_DONE : S_CMP;
			end
			S_CMP: begin
				state_d = sts.rd_ge ? S_ENQ_DONE : S_SCAN;
			end
			S_ENQ_DONE: begin
				state_d = S_FINISH;
			end
			S_RD_HEAD: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd       = '0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.latch_in = req_valid;
			end
			S_DISPATCH: begin
				cmd.status_load = 1'b1;
				unique case (sts.op)
					OP_ENQ: begin
						if (sts.full) begin
							cmd.status_code = STAT_FULL;
							cmd.cap_head    = 1'b1;
						end else begin
							cmd.status_code = STAT_OK;
							cmd.scan_init   = 1'b1;
						end
					end
					OP_DEQ: begin
						if (sts.empty) begin
							cmd.status_code = STAT_EMPTY;
							cmd.cap_zero    = 1'b1;
						end else begin
							cmd.status_code = STAT_OK;
							cmd.cap_head    = 1'b1;
							cmd.deq_commit  = 1'b1;
						end
					end
					default: begin
						if (sts.empty) begin
							cmd.status_code = STAT_EMPTY;
							cmd.cap_zero    = 1'b1;
						end else begin
							cmd.status_code = STAT_OK;
							cmd.cap_head    = 1'b1;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_done) cmd.write_new = 1'b1;
				else cmd.scan_read = 1'b1;
			end
			S_CMP: begin
				if (sts.rd_ge) cmd.write_new = 1'b1;
				else cmd.write_shift = 1'b1;
			end
			S_ENQ_DONE: begin
				cmd.cap_head = 1'b1;
			end
			S_RD_HEAD: begin
				cmd.head_load = 1'b1;
			end
			S_FINISH: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/spq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dp: storage and datapath of the stable priority queue
// Keeps the sorted items in a circular RAM with head and tail pointers, a
// register copy of the head item, the insertion scan pointer and the
// response register.
// ----------------------------------------------------------------------------
module spq_dp
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int PTR_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WORD_W = PRIORITY_BITS + DATA_BITS;

	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);

	// Latched request.
	logic [1:0]                      op_q;
	logic [DATA_BITS-1:0]            in_data_q;
	logic signed [PRIORITY_BITS-1:0] in_prio_q;

	// Store bookkeeping.
	logic [PTR_W-1:0] head_ptr_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [DATA_BITS-1:0]            head_data_q;
	logic signed [PRIORITY_BITS-1:0] head_prio_q;

	// Insertion scan.
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] pos_q;

	// Staged result.
	logic [1:0]                      status_q;
	logic [DATA_BITS-1:0]            res_data_q;
	logic signed [PRIORITY_BITS-1:0] res_prio_q;

	// Response register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// RAM ports.
	logic                            ram_we;
	logic [PTR_W-1:0]                ram_waddr;
	logic [WORD_W-1:0]               ram_wdata;
	logic                            ram_re;
	logic [PTR_W-1:0]                ram_raddr;
	logic [WORD_W-1:0]               ram_rdata;
	logic [DATA_BITS-1:0]            rd_data;
	logic signed [PRIORITY_BITS-1:0] rd_prio;

	logic [PTR_W-1:0] head_next;
	logic [PTR_W-1:0] tail_next;
	logic [PTR_W-1:0] wr_prev;
	logic             out_free;

	// Circular pointer steps.
	assign head_next = (head_ptr_q == LAST_PTR) ? '0 : head_ptr_q + 1'b1;
	assign tail_next = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
	assign wr_prev   = (wr_ptr_q == '0) ? LAST_PTR : wr_ptr_q - 1'b1;

	// Read word split.
	assign rd_data = ram_rdata[DATA_BITS-1:0];
	assign rd_prio = signed'(ram_rdata[WORD_W-1:DATA_BITS]);

	// RAM port selection: new item or shifted item on the write side, new
	// head or scan neighbor on the read side.
	always_comb begin
		ram_we    = cmd.write_new || cmd.write_shift;
		ram_waddr = wr_ptr_q;
		ram_wdata = cmd.write_new ? {in_prio_q, in_data_q} : ram_rdata;
		ram_re    = cmd.deq_commit || cmd.scan_read;
		ram_raddr = cmd.deq_commit ? head_next : wr_prev;
	end

	spq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Request latch.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q      <= req.opcode;
			in_data_q <= req.item_data;
			in_prio_q <= req.item_priority;
		end
	end

	// Pointers and item count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_q     <= '0;
			count_q    <= '0;
		end else begin
			if (cmd.deq_commit) begin
				head_ptr_q <= head_next;
				count_q    <= count_q - 1'b1;
			end else if (cmd.write_new) begin
				tail_q  <= tail_next;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Register copy of the head slot.
	always_ff @(posedge clk) begin
		if (cmd.head_load) begin
			head_data_q <= rd_data;
			head_prio_q <= rd_prio;
		end else if (cmd.write_new && (pos_q == '0)) begin
			head_data_q <= in_data_q;
			head_prio_q <= in_prio_q;
		end
	end

	// Insertion scan walks from the tail toward the head.
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			wr_ptr_q <= tail_q;
			pos_q    <= count_q;
		end else if (cmd.write_shift) begin
			wr_ptr_q <= wr_prev;
			pos_q    <= pos_q - 1'b1;
		end
	end

	// Staged result fields.
	always_ff @(posedge clk) begin
		if (cmd.status_load) begin
			status_q <= cmd.status_code;
		end
		if (cmd.cap_zero) begin
			res_data_q <= '0;
			res_prio_q <= '0;
		end else if (cmd.cap_head) begin
			res_data_q <= head_data_q;
			res_prio_q <= head_prio_q;
		end
	end

	// Response register; a waiting beat does not block the next request.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status        <= status_q;
			rsp_q.head_data     <= res_data_q;
			rsp_q.head_priority <= res_prio_q;
			rsp_q.item_count    <= COUNT_BITS'(count_q);
			rsp_q.is_empty      <= (count_q == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status toward the controller.
	always_comb begin
		sts.op        = op_q;
		sts.empty     = (count_q == '0);
		sts.full      = (count_q == CNT_W'(CAPACITY));
		sts.last_item = (count_q == CNT_W'(1));
		sts.scan_done = (pos_q == '0);
		sts.rd_ge     = (rd_prio >= in_prio_q);
		sts.out_free  = out_free;
	end

`ifndef SYNTHESIS
	// The store never holds more than its capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("item count exceeds capacity");

	// An empty store has its head and tail pointers together.
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_ptr_q == tail_q))
		else $error("head and tail pointers differ on an empty store");

	// Placing the new item adds exactly one stored item.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_new |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("insertion did not add one item");

	// A response is loaded only into a free output register.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("response register overwritten while held");
`endif

endmodule
`default_nettype wire

// ===== rtl/stable_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded stable priority queue
// Sorted store of data words with signed priorities; enqueue, dequeue and
// peek operations, one response beat per request beat.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one response for
// it. Items sit in a circular RAM of CAPACITY entries in priority order, the
// head held in a register. A dequeue that leaves items in the store reloads
// the head with one RAM read. An enqueue moves back one slot each stored item
// of lower priority: each move is a RAM read followed by a compare and write,
// so the number of such items sets the enqueue time. The response register
// lets the next request be accepted while a response beat still waits. The
// store needs no clearing after reset.
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	cmd_t cmd;
	sts_t sts;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	spq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
